// ===== rtl/cbyx_pkg.sv =====
// ----------------------------------------------------------------------------
// cbyx_pkg: shared types and constants for the cubic Bezier y-from-x solver.
// Fixed-point scale, iteration cap and the request/response transaction types.
// ----------------------------------------------------------------------------
package cbyx_pkg;

   // Curve parameter scale: U_ONE stands for 1.0.
   localparam logic [30:0] U_ONE = 31'h7FFF_FFFF;

   // Bisection step cap and the width of its counter.
   localparam int MAX_ITERATIONS = 32;
   localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

   typedef struct packed {
      logic signed [31:0] p0x;
      logic signed [31:0] p1x;
      logic signed [31:0] p2x;
      logic signed [31:0] p3x;
      logic signed [31:0] p0y;
      logic signed [31:0] p1y;
      logic signed [31:0] p2y;
      logic signed [31:0] p3y;
      logic signed [31:0] target_x;
   } req_type;

   typedef struct packed {
      logic signed [31:0] y_value;
      logic        [30:0] param_found;
      logic               converged;
   } rsp_type;

endpackage

// ===== rtl/cbyx_lerp.sv =====
// ----------------------------------------------------------------------------
// cbyx_lerp: fixed-point linear interpolation unit.
// Computes ((U_ONE-u)*a + u*b) / U_ONE, truncated toward zero, in six stages.
// ----------------------------------------------------------------------------
module cbyx_lerp (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   input  logic        [30:0] u,
   output logic               done,
   output logic signed [31:0] result
);
   import cbyx_pkg::*;

   logic        [5:0]  valid_ff;
   logic signed [32:0] diff;
   logic signed [63:0] prod_in, prod_ff;
   logic signed [63:0] ma_in, ma_ff;
   logic signed [63:0] acc_in, acc_ff;
   logic               neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic        [62:0] mag_in, mag_ff;
   logic        [31:0] q0_ff;
   logic        [32:0] r1_in, r1_ff;
   logic        [31:0] r2_in, r2_ff;
   logic        [31:0] qa_in, qa_ff;
   logic        [31:0] q_fin;
   logic signed [31:0] res_in, res_ff;

   // The sum is rewritten as U_ONE*a + u*(b-a); U_ONE*a is a shift and a subtract.
   always_comb begin
      diff    = $signed({b[31], b}) - $signed({a[31], a});
      prod_in = 64'(diff) * 64'($signed({1'b0, u}));
      ma_in   = $signed({a[31], a, 31'b0}) - $signed({{32{a[31]}}, a});
   end

   assign acc_in = ma_ff + prod_ff;
   assign mag_in = acc_ff[63] ? 63'(-acc_ff) : acc_ff[62:0];

   // Division by 2^31-1: since 2^31 is 1 modulo the divisor, the high part
   // folds into the low part twice, and one final compare settles the quotient.
   assign r1_in = {1'b0, mag_ff[62:31]} + {2'b0, mag_ff[30:0]};
   assign r2_in = {1'b0, r1_ff[30:0]} + {30'b0, r1_ff[32:31]};
   assign qa_in = q0_ff + {30'b0, r1_ff[32:31]};
   assign q_fin = qa_ff + {31'b0, (r2_ff >= {1'b0, U_ONE})};
   assign res_in = neg5_ff ? $signed(-q_fin) : $signed(q_fin);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[4:0], start};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ma_ff   <= ma_in;
      acc_ff  <= acc_in;
      neg2_ff <= acc_in[63];
      mag_ff  <= mag_in;
      neg3_ff <= neg2_ff;
      q0_ff   <= mag_ff[62:31];
      r1_ff   <= r1_in;
      neg4_ff <= neg3_ff;
      r2_ff   <= r2_in;
      qa_ff   <= qa_in;
      neg5_ff <= neg4_ff;
      res_ff  <= res_in;
   end

   assign done   = valid_ff[5];
   assign result = res_ff;

endmodule

// ===== rtl/cubic_bezier_y_from_x_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_y_from_x_core: solves y on a cubic Bezier curve for a given x.
// A response follows once a guess is within tolerance or the 32-step cap is
// reached; each step evaluates the curve with six passes through the one
// shared lerp unit, plus bookkeeping.
// Throughput: one transaction at a time; busy stays high until the response.
// Reset: synchronous, clears the sequencer and sets x_tolerance to zero.
// ----------------------------------------------------------------------------
module cubic_bezier_y_from_x_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cbyx_pkg::req_type req_data,
   output logic              rsp_strobe,
   output cbyx_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic       [30:0] csr_data
);
   import cbyx_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ISSUE  = 6'b000010,
      ST_WAIT   = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_BISECT = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   // Lerp order within one curve evaluation.
   localparam logic [2:0] LERP_Q0  = 3'd0;
   localparam logic [2:0] LERP_Q1  = 3'd1;
   localparam logic [2:0] LERP_Q2  = 3'd2;
   localparam logic [2:0] LERP_R0  = 3'd3;
   localparam logic [2:0] LERP_R1  = 3'd4;
   localparam logic [2:0] LERP_FIN = 3'd5;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic        [30:0] tol_ff, tol_in;
   logic        [30:0] lo_ff, lo_in, hi_ff, hi_in, guess_ff, guess_in;
   logic [ITER_W-1:0]  steps_ff, steps_in;
   logic        [2:0]  lerp_ff, lerp_in;
   logic               use_y_ff, use_y_in;
   logic signed [31:0] q0_ff, q0_in, q1_ff, q1_in, q2_ff, q2_in;
   logic signed [31:0] r0_ff, r0_in, r1_ff, r1_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [32:0] err_ff, err_in;
   logic               conv_ff, conv_in;

   logic signed [31:0] c0, c1, c2, c3;
   logic signed [31:0] op_a, op_b;
   logic               lerp_start, lerp_done;
   logic signed [31:0] lerp_res;
   logic signed [32:0] tol_pos, tol_neg;
   logic               in_tol;

   cbyx_lerp u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .a      (op_a),
      .b      (op_b),
      .u      (guess_ff),
      .done   (lerp_done),
      .result (lerp_res)
   );

   always_comb begin
      c0 = use_y_ff ? req_ff.p0y : req_ff.p0x;
      c1 = use_y_ff ? req_ff.p1y : req_ff.p1x;
      c2 = use_y_ff ? req_ff.p2y : req_ff.p2x;
      c3 = use_y_ff ? req_ff.p3y : req_ff.p3x;
      case (lerp_ff)
         LERP_Q0: begin op_a = c0;    op_b = c1;    end
         LERP_Q1: begin op_a = c1;    op_b = c2;    end
         LERP_Q2: begin op_a = c2;    op_b = c3;    end
         LERP_R0: begin op_a = q0_ff; op_b = q1_ff; end
         LERP_R1: begin op_a = q1_ff; op_b = q2_ff; end
         default: begin op_a = r0_ff; op_b = r1_ff; end
      endcase
   end

   assign lerp_start = (state_ff == ST_ISSUE);

   assign tol_pos = $signed({2'b0, tol_ff});
   assign tol_neg = -tol_pos;
   assign in_tol  = (err_ff <= tol_pos) && (err_ff >= tol_neg);

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      tol_in   = tol_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      guess_in = guess_ff;
      steps_in = steps_ff;
      lerp_in  = lerp_ff;
      use_y_in = use_y_ff;
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      q2_in    = q2_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      y_in     = y_ff;
      err_in   = err_ff;
      conv_in  = conv_ff;

      if (csr_valid && csr_ready) begin
         tol_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               lo_in    = '0;
               hi_in    = U_ONE;
               guess_in = U_ONE >> 1;
               steps_in = '0;
               lerp_in  = LERP_Q0;
               use_y_in = 1'b0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (lerp_done) begin
               case (lerp_ff)
                  LERP_Q0: q0_in = lerp_res;
                  LERP_Q1: q1_in = lerp_res;
                  LERP_Q2: q2_in = lerp_res;
                  LERP_R0: r0_in = lerp_res;
                  LERP_R1: r1_in = lerp_res;
                  default: ;
               endcase
               if (lerp_ff != LERP_FIN) begin
                  lerp_in  = lerp_ff + 3'd1;
                  state_in = ST_ISSUE;
               end else if (use_y_ff) begin
                  y_in     = lerp_res;
                  state_in = ST_DONE;
               end else begin
                  err_in   = $signed({lerp_res[31], lerp_res})
                           - $signed({req_ff.target_x[31], req_ff.target_x});
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (in_tol || steps_ff == ITER_W'(MAX_ITERATIONS)) begin
               conv_in  = in_tol;
               use_y_in = 1'b1;
               lerp_in  = LERP_Q0;
               state_in = ST_ISSUE;
            end else begin
               if (err_ff > 33'sd0) begin
                  hi_in = guess_ff;
               end else begin
                  lo_in = guess_ff;
               end
               state_in = ST_BISECT;
            end
         end
         ST_BISECT: begin
            guess_in = lo_ff + ((hi_ff - lo_ff) >> 1);
            steps_in = steps_ff + ITER_W'(1);
            lerp_in  = LERP_Q0;
            state_in = ST_ISSUE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff   <= '0;
         steps_ff <= '0;
         lerp_ff  <= LERP_Q0;
         use_y_ff <= 1'b0;
         lo_ff    <= '0;
         hi_ff    <= U_ONE;
         guess_ff <= U_ONE >> 1;
      end else begin
         state_ff <= state_in;
         tol_ff   <= tol_in;
         steps_ff <= steps_in;
         lerp_ff  <= lerp_in;
         use_y_ff <= use_y_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         guess_ff <= guess_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      q0_ff   <= q0_in;
      q1_ff   <= q1_in;
      q2_ff   <= q2_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      y_ff    <= y_in;
      err_ff  <= err_in;
      conv_ff <= conv_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = (state_ff == ST_DONE);

   always_comb begin
      rsp_data.y_value     = y_ff;
      rsp_data.param_found = guess_ff;
      rsp_data.converged   = conv_ff;
   end

   // A response that missed the tolerance must have used every bisection step.
   a_cap_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.converged |-> steps_ff == ITER_W'(MAX_ITERATIONS))
      else $error("non-converged response before the step cap");

   // The shared lerp unit only completes while the sequencer waits for it.
   a_lerp_owned: assert property (@(posedge clock) disable iff (reset)
      lerp_done |-> state_ff == ST_WAIT)
      else $error("lerp result arrived outside the wait state");

   // The guess never leaves the current bisection bracket.
   a_bracket: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |-> guess_ff >= lo_ff && guess_ff <= hi_ff)
      else $error("guess outside the bisection bracket");

   // An accepted transaction keeps the core busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule
